>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/lfm_pkg.sv
// ----------------------------------------------------------------------------
// lfm_pkg
// constants, types and cosine/sine table builder for the chirp generator
// ----------------------------------------------------------------------------
`default_nettype none

package lfm_pkg;

   localparam int PHASE_TABLE_BITS = 12;
   localparam int MAX_LENGTH       = 65536;
   localparam int MAX_BEAMS        = 256;
   localparam int BEAM_CAP         = (MAX_BEAMS > 256) ? 256 : MAX_BEAMS;

   // octant table: quarter wave folded about pi/4
   localparam int TRIG_AW    = PHASE_TABLE_BITS - 2;
   localparam int QUARTER    = 1 << TRIG_AW;
   localparam int EIGHTH     = QUARTER / 2;
   localparam int TRIG_DEPTH = EIGHTH + 1;
   localparam int TRIG_W     = 30;

   localparam int ANG_SHL = (PHASE_TABLE_BITS <= 15) ? 15 - PHASE_TABLE_BITS : 0;
   localparam int ANG_SHR = (PHASE_TABLE_BITS > 15) ? PHASE_TABLE_BITS - 15 : 0;

   localparam logic [63:0] ONE_Q62        = 64'd1 << 62;
   localparam logic [63:0] QUARTER_PI_Q50 = 64'h0003_243F_6A88_85A3;

   // series term divisors as reciprocals, floor(2^74 / d) + 1, exact for 64-bit terms
   localparam int          RECIP_SHIFT = 74;
   localparam logic [79:0] RECIP_ONE   = 80'd1 << RECIP_SHIFT;

   // sine terms: d = 2k * (2k + 1), k from 14 down to 1
   localparam logic [14:1][79:0] RECIP_SIN = {
      RECIP_ONE / 80'd812 + 80'd1, RECIP_ONE / 80'd702 + 80'd1,
      RECIP_ONE / 80'd600 + 80'd1, RECIP_ONE / 80'd506 + 80'd1,
      RECIP_ONE / 80'd420 + 80'd1, RECIP_ONE / 80'd342 + 80'd1,
      RECIP_ONE / 80'd272 + 80'd1, RECIP_ONE / 80'd210 + 80'd1,
      RECIP_ONE / 80'd156 + 80'd1, RECIP_ONE / 80'd110 + 80'd1,
      RECIP_ONE / 80'd72 + 80'd1,  RECIP_ONE / 80'd42 + 80'd1,
      RECIP_ONE / 80'd20 + 80'd1,  RECIP_ONE / 80'd6 + 80'd1
   };

   // cosine terms: d = (2k - 1) * 2k, k from 14 down to 1
   localparam logic [14:1][79:0] RECIP_COS = {
      RECIP_ONE / 80'd756 + 80'd1, RECIP_ONE / 80'd650 + 80'd1,
      RECIP_ONE / 80'd552 + 80'd1, RECIP_ONE / 80'd462 + 80'd1,
      RECIP_ONE / 80'd380 + 80'd1, RECIP_ONE / 80'd306 + 80'd1,
      RECIP_ONE / 80'd240 + 80'd1, RECIP_ONE / 80'd182 + 80'd1,
      RECIP_ONE / 80'd132 + 80'd1, RECIP_ONE / 80'd90 + 80'd1,
      RECIP_ONE / 80'd56 + 80'd1,  RECIP_ONE / 80'd30 + 80'd1,
      RECIP_ONE / 80'd12 + 80'd1,  RECIP_ONE / 80'd2 + 80'd1
   };

   typedef enum logic [2:0] {
      CSR_START_STEP  = 3'd0,
      CSR_STEP_CHANGE = 3'd1,
      CSR_AMPLITUDE   = 3'd2,
      CSR_IQ_ENABLE   = 3'd3,
      CSR_CHIRP_LEN   = 3'd4,
      CSR_BEAM_TOTAL  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        start_step;
      logic signed [31:0] step_change;
      logic [14:0]        amplitude;
      logic               iq_enable;
      logic [15:0]        len_m1;
      logic [7:0]         beams_m1;
   } cfg_type;

   typedef struct packed {
      logic [TRIG_AW-1:0] addr;
      logic               flip;
      logic [1:0]         quad;
      logic [15:0]        sample_number;
      logic [7:0]         beam_number;
      logic               chirp_end;
      logic               burst_end;
   } slot_type;

   typedef struct packed {
      logic signed [15:0] in_phase;
      logic signed [15:0] quadrature;
      logic [15:0]        sample_number;
      logic [7:0]         beam_number;
      logic               chirp_end;
      logic               burst_end;
   } rsp_type;

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // floor(n / d) through the reciprocal m of d
   function automatic logic [63:0] recip_div(input logic [63:0] n, input logic [79:0] m);
      logic [143:0] p;
      p = {80'd0, n} * {64'd0, m};
      return p[RECIP_SHIFT +: 64];
   endfunction

   function automatic logic [14:0] scale_round(input logic [63:0] v);
      logic [63:0] t;
      t = (v >> 15) * 64'd32767 + (64'd1 << 46);
      return t[61:47];
   endfunction

   // {cos, sin} of a * pi/4 / EIGHTH, rounded to the 32767 scale
   function automatic logic [TRIG_W-1:0] trig_entry(input int unsigned a);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] st;
      logic [63:0] ss;
      logic [63:0] ct;
      logic [63:0] cs;
      int          k;
      x  = ((QUARTER_PI_Q50 * 64'(a)) << ANG_SHL) >> ANG_SHR;
      x2 = mul_q62(x, x);
      st = x;
      ss = x;
      ct = ONE_Q62;
      cs = ONE_Q62;
      for (k = 1; k <= 14; k++) begin
         st = recip_div(mul_q62(st, x2), RECIP_SIN[4'(k)]);
         ct = recip_div(mul_q62(ct, x2), RECIP_COS[4'(k)]);
         if (k % 2 == 1) begin
            ss = ss - st;
            cs = cs - ct;
         end else begin
            ss = ss + st;
            cs = cs + ct;
         end
      end
      return {scale_round(cs), scale_round(ss)};
   endfunction

endpackage

`default_nettype wire

>>> rtl/lfm_csr.sv
// ----------------------------------------------------------------------------
// lfm_csr
// configuration registers with clamped chirp length and beam count
// ----------------------------------------------------------------------------
`default_nettype none

module lfm_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_valid,
   input  wire logic [2:0]      csr_index,
   input  wire logic [31:0]     csr_data,
   output lfm_pkg::cfg_type     cfg
);

   logic [31:0] start_step_ff,  start_step_in;
   logic [31:0] step_change_ff, step_change_in;
   logic [14:0] amplitude_ff,   amplitude_in;
   logic        iq_enable_ff,   iq_enable_in;
   logic [16:0] chirp_len_ff,   chirp_len_in;
   logic [8:0]  beam_total_ff,  beam_total_in;

   always_comb begin
      start_step_in  = start_step_ff;
      step_change_in = step_change_ff;
      amplitude_in   = amplitude_ff;
      iq_enable_in   = iq_enable_ff;
      chirp_len_in   = chirp_len_ff;
      beam_total_in  = beam_total_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lfm_pkg::CSR_START_STEP:  start_step_in  = csr_data;
            lfm_pkg::CSR_STEP_CHANGE: step_change_in = csr_data;
            lfm_pkg::CSR_AMPLITUDE:   amplitude_in   = csr_data[14:0];
            lfm_pkg::CSR_IQ_ENABLE:   iq_enable_in   = csr_data[0];
            lfm_pkg::CSR_CHIRP_LEN:   chirp_len_in   = csr_data[16:0];
            lfm_pkg::CSR_BEAM_TOTAL:  beam_total_in  = csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_step_ff  <= '0;
         step_change_ff <= '0;
         amplitude_ff   <= 15'd32767;
         iq_enable_ff   <= 1'b1;
         chirp_len_ff   <= 17'd1024;
         beam_total_ff  <= 9'd1;
      end else begin
         start_step_ff  <= start_step_in;
         step_change_ff <= step_change_in;
         amplitude_ff   <= amplitude_in;
         iq_enable_ff   <= iq_enable_in;
         chirp_len_ff   <= chirp_len_in;
         beam_total_ff  <= beam_total_in;
      end
   end

   logic [16:0] len_m1_wide;
   logic [8:0]  beams_m1_wide;

   always_comb begin
      if (chirp_len_ff == '0) begin
         len_m1_wide = '0;
      end else if (chirp_len_ff > 17'(lfm_pkg::MAX_LENGTH)) begin
         len_m1_wide = 17'(lfm_pkg::MAX_LENGTH - 1);
      end else begin
         len_m1_wide = chirp_len_ff - 17'd1;
      end
      if (beam_total_ff == '0) begin
         beams_m1_wide = '0;
      end else if (beam_total_ff > 9'(lfm_pkg::BEAM_CAP)) begin
         beams_m1_wide = 9'(lfm_pkg::BEAM_CAP - 1);
      end else begin
         beams_m1_wide = beam_total_ff - 9'd1;
      end
   end

   assign cfg.start_step  = start_step_ff;
   assign cfg.step_change = signed'(step_change_ff);
   assign cfg.amplitude   = amplitude_ff;
   assign cfg.iq_enable   = iq_enable_ff;
   assign cfg.len_m1      = len_m1_wide[15:0];
   assign cfg.beams_m1    = beams_m1_wide[7:0];

endmodule

`default_nettype wire

>>> rtl/lfm_phase_seq.sv
// ----------------------------------------------------------------------------
// lfm_phase_seq
// sample and beam counters, phase accumulator and table address stage
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfm_phase_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              req_valid,
   input  wire logic              restart,
   input  lfm_pkg::cfg_type       cfg,
   output logic                   slot_valid_ff,
   output lfm_pkg::slot_type      slot_ff
);

   localparam int PTB = lfm_pkg::PHASE_TABLE_BITS;
   localparam int AW  = lfm_pkg::TRIG_AW;

   logic [15:0] sample_ff, sample_in;
   logic [7:0]  beam_ff,   beam_in;
   logic [31:0] phase_ff,  phase_in;
   logic [31:0] step_ff,   step_in;
   logic        slot_valid_in;
   lfm_pkg::slot_type slot_in;

   logic        req_fire;
   logic [15:0] cnt;
   logic [7:0]  beam;
   logic        start;
   logic [31:0] phase;
   logic [31:0] step;
   logic        cend;
   logic        bend;
   logic [PTB-1:0] idx;
   logic [AW-1:0]  r;
   logic [AW:0]    fold;
   logic           flip;

   assign req_fire = req_valid && adv;

   always_comb begin
      cnt   = restart ? '0 : sample_ff;
      beam  = restart ? '0 : beam_ff;
      start = (cnt == '0);
      phase = start ? '0 : phase_ff;
      step  = start ? cfg.start_step : step_ff;
      cend  = (cnt >= cfg.len_m1);
      bend  = cend && (beam >= cfg.beams_m1);

      idx  = phase[31 -: PTB];
      r    = idx[AW-1:0];
      flip = (r > AW'(lfm_pkg::EIGHTH));
      fold = (AW + 1)'(lfm_pkg::QUARTER) - {1'b0, r};

      slot_in.addr          = flip ? fold[AW-1:0] : r;
      slot_in.flip          = flip;
      slot_in.quad          = idx[PTB-1 -: 2];
      slot_in.sample_number = cnt;
      slot_in.beam_number   = beam;
      slot_in.chirp_end     = cend;
      slot_in.burst_end     = bend;
      slot_valid_in         = req_valid;

      phase_in  = phase_ff;
      step_in   = step_ff;
      sample_in = sample_ff;
      beam_in   = beam_ff;
      if (req_fire) begin
         phase_in = phase + step;
         step_in  = step + cfg.step_change;
         if (cend) begin
            sample_in = '0;
            beam_in   = bend ? '0 : beam + 8'd1;
         end else begin
            sample_in = cnt + 16'd1;
            beam_in   = beam;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff     <= '0;
         beam_ff       <= '0;
         phase_ff      <= '0;
         step_ff       <= '0;
         slot_valid_ff <= 1'b0;
      end else begin
         sample_ff <= sample_in;
         beam_ff   <= beam_in;
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         if (adv) begin
            slot_valid_ff <= slot_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         slot_ff <= slot_in;
      end
   end

   // chirp start always reads the table at zero phase
   `ASSERT_NEXT(a_start_zero_phase, clock, reset, req_fire && start,
      slot_ff.addr == '0 && !slot_ff.flip && slot_ff.quad == 2'd0, "chirp start not at zero phase")
   `ASSERT_IMPLIES(a_burst_in_chirp, clock, reset, slot_valid_ff && slot_ff.burst_end,
      slot_ff.chirp_end, "burst end without chirp end")
   `ASSERT_NEXT(a_wrap_after_end, clock, reset, req_fire && cend,
      sample_ff == '0, "sample counter did not wrap after chirp end")
   `ASSERT_IMPLIES(a_addr_in_octant, clock, reset, slot_valid_ff,
      slot_ff.addr <= AW'(lfm_pkg::EIGHTH), "table address beyond octant")

endmodule

`default_nettype wire

>>> rtl/lfm_trig_rom.sv
// ----------------------------------------------------------------------------
// lfm_trig_rom
// octant cosine and sine table with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lfm_trig_rom (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [lfm_pkg::TRIG_AW-1:0]   addr,
   output logic      [lfm_pkg::TRIG_W-1:0]    rd_data_ff
);

   logic [lfm_pkg::TRIG_W-1:0] rom [lfm_pkg::TRIG_DEPTH];
   logic [lfm_pkg::TRIG_W-1:0] rd_data_in;

   for (genvar i = 0; i < lfm_pkg::TRIG_DEPTH; i++) begin : g_entry
      assign rom[i] = lfm_pkg::trig_entry(i);
   end

   assign rd_data_in = rom[addr];

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= rd_data_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lfm_scaler.sv
// ----------------------------------------------------------------------------
// lfm_scaler
// quadrant unfolding, amplitude scaling and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfm_scaler (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         slot_valid,
   input  lfm_pkg::slot_type                 slot,
   input  wire logic [lfm_pkg::TRIG_W-1:0]   trig,
   input  lfm_pkg::cfg_type                  cfg,
   output logic                              rsp_valid_ff,
   output lfm_pkg::rsp_type                  rsp_ff
);

   logic              hold_valid_ff, hold_valid_in;
   lfm_pkg::slot_type hold_ff;
   logic              rsp_valid_in;
   lfm_pkg::rsp_type  rsp_in;

   logic signed [15:0] c0;
   logic signed [15:0] s0;
   logic signed [15:0] bc;
   logic signed [15:0] bs;
   logic signed [15:0] tc;
   logic signed [15:0] ts;
   logic signed [15:0] amp;
   logic signed [31:0] prod_i;
   logic signed [31:0] prod_q;

   // slot sideband is registered alongside the table read
   assign hold_valid_in = slot_valid;

   always_comb begin
      c0  = signed'({1'b0, trig[29:15]});
      s0  = signed'({1'b0, trig[14:0]});
      bc  = hold_ff.flip ? s0 : c0;
      bs  = hold_ff.flip ? c0 : s0;
      case (hold_ff.quad)
         2'd0: begin
            tc = bc;
            ts = bs;
         end
         2'd1: begin
            tc = -bs;
            ts = bc;
         end
         2'd2: begin
            tc = -bc;
            ts = -bs;
         end
         default: begin
            tc = bs;
            ts = -bc;
         end
      endcase
      amp    = signed'({1'b0, cfg.amplitude});
      prod_i = amp * tc;
      prod_q = amp * ts;

      // floor division by 32768 is an arithmetic shift
      rsp_in.in_phase      = prod_i[30:15];
      rsp_in.quadrature    = cfg.iq_enable ? prod_q[30:15] : '0;
      rsp_in.sample_number = hold_ff.sample_number;
      rsp_in.beam_number   = hold_ff.beam_number;
      rsp_in.chirp_end     = hold_ff.chirp_end;
      rsp_in.burst_end     = hold_ff.burst_end;
      rsp_valid_in         = hold_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (adv) begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hold_ff <= slot;
         rsp_ff  <= rsp_in;
      end
   end

   `ASSERT_NEXT(a_result_follows, clock, reset, adv && hold_valid_ff,
      rsp_valid_ff, "held sample did not reach the result register")

endmodule

`default_nettype wire

>>> rtl/lfm_chirp_generator_top.sv
// ----------------------------------------------------------------------------
// lfm_chirp_generator_top: linear fm chirp source, one sample per req beat
// a req beat is registered by the counter/phase stage, the registered table read and
// the scaler in turn; one beat per cycle sustained while no result waits on rsp_tready
// the three stages stall together only while a result waits on rsp_tready
// reset clears counters, phase and pipeline; registers return to defaults
// ----------------------------------------------------------------------------
`default_nettype none

module lfm_chirp_generator_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] restart, [7:1] zero

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] in_phase, [31:16] quadrature, [47:32] sample_number, [55:48] beam_number
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tlast,   // chirp_end
   output logic [0:0]       rsp_tuser,   // [0] burst_end

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   lfm_pkg::cfg_type  cfg;
   lfm_pkg::slot_type slot;
   lfm_pkg::rsp_type  rsp;
   logic                        slot_valid;
   logic [lfm_pkg::TRIG_W-1:0]  trig;
   logic                        adv;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   lfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lfm_phase_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .req_valid     (req_tvalid),
      .restart       (req_tdata[0]),
      .cfg           (cfg),
      .slot_valid_ff (slot_valid),
      .slot_ff       (slot)
   );

   lfm_trig_rom u_rom (
      .clock      (clock),
      .en         (adv),
      .addr       (slot.addr),
      .rd_data_ff (trig)
   );

   lfm_scaler u_scaler (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .slot_valid   (slot_valid),
      .slot         (slot),
      .trig         (trig),
      .cfg          (cfg),
      .rsp_valid_ff (rsp_tvalid),
      .rsp_ff       (rsp)
   );

   assign rsp_tdata = {rsp.beam_number, rsp.sample_number,
                       rsp.quadrature, rsp.in_phase};
   assign rsp_tlast = rsp.chirp_end;
   assign rsp_tuser = rsp.burst_end;

endmodule

`default_nettype wire

>>> tb/sv/tb_lfm_chirp_generator_top.sv
// ----------------------------------------------------------------------------
// tb_lfm_chirp_generator_top
// Drives request beats, some with restart set, into the chirp generator and
// compares every output sample with an in-order prediction of phase, trig
// lookup, scaling and the sample, beam and end markers. Register settings
// change between phases while the block is idle. Both stream sides idle in
// random bursts, and there is a long output hold that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lfm_chirp_generator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS  = 900;
   localparam int CLOSING_ITEMS = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;

   class chirp_scoreboard;
      localparam logic [63:0] UNIT_Q62    = 64'd1 << 62;
      localparam logic [63:0] QTR_PI_Q50  = 64'h0003_243F_6A88_85A3;
      localparam int          TBITS       = lfm_pkg::PHASE_TABLE_BITS;
      localparam int          QTR         = 1 << (TBITS - 2);
      localparam int          OCT         = QTR / 2;
      localparam int          ANG_UP      = (TBITS <= 15) ? 15 - TBITS : 0;
      localparam int          ANG_DN      = (TBITS > 15) ? TBITS - 15 : 0;

      logic [31:0] start_step;
      logic [31:0] step_change;
      logic [14:0] amplitude;
      logic        iq_enable;
      logic [16:0] chirp_length;
      logic [8:0]  beam_total;

      logic [15:0] sample_cnt;
      logic [7:0]  beam_cnt;
      logic [31:0] phase_acc;
      logic [31:0] phase_step;

      int               cos_oct[];
      int               sin_oct[];
      lfm_pkg::rsp_type expected_samples[$];
      int               errors;
      int               checked;

      function new();
         build_octant();
         start_step   = '0;
         step_change  = '0;
         amplitude    = 15'h7FFF;
         iq_enable    = 1'b1;
         chirp_length = 17'd1024;
         beam_total   = 9'd1;
         sample_cnt   = '0;
         beam_cnt     = '0;
         phase_acc    = '0;
         phase_step   = '0;
         errors       = 0;
         checked      = 0;
      endfunction

      function logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
         logic [127:0] p;
         p = 128'(a) * 128'(b);
         return p[125:62];
      endfunction

      function int round_32767(input logic [63:0] v);
         logic [63:0] t;
         t = (v >> 15) * 64'd32767 + (64'd1 << 46);
         return int'(t >> 47);
      endfunction

      // taylor series for cos and sin over the first octant
      function void build_octant();
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] st;
         logic [63:0] ss;
         logic [63:0] ct;
         logic [63:0] cs;
         int          a;
         int          k;
         cos_oct = new[OCT + 1];
         sin_oct = new[OCT + 1];
         for (a = 0; a <= OCT; a++) begin
            x  = ((QTR_PI_Q50 * 64'(a)) << ANG_UP) >> ANG_DN;
            x2 = q62_mul(x, x);
            st = x;
            ss = x;
            ct = UNIT_Q62;
            cs = UNIT_Q62;
            for (k = 1; k <= 14; k++) begin
               st = q62_mul(st, x2) / 64'((2 * k) * (2 * k + 1));
               ct = q62_mul(ct, x2) / 64'((2 * k - 1) * (2 * k));
               if (k % 2 == 1) begin
                  ss = ss - st;
                  cs = cs - ct;
               end else begin
                  ss = ss + st;
                  cs = cs + ct;
               end
            end
            cos_oct[a] = round_32767(cs);
            sin_oct[a] = round_32767(ss);
         end
      endfunction

      function logic [15:0] scaled(input int t);
         int prod;
         prod = int'({17'd0, amplitude}) * t;
         prod = prod >>> 15;
         return 16'(prod);
      endfunction

      function void write_reg(input logic [2:0] idx, input logic [31:0] data);
         case (idx)
            lfm_pkg::CSR_START_STEP:  start_step   = data;
            lfm_pkg::CSR_STEP_CHANGE: step_change  = data;
            lfm_pkg::CSR_AMPLITUDE:   amplitude    = data[14:0];
            lfm_pkg::CSR_IQ_ENABLE:   iq_enable    = data[0];
            lfm_pkg::CSR_CHIRP_LEN:   chirp_length = data[16:0];
            lfm_pkg::CSR_BEAM_TOTAL:  beam_total   = data[8:0];
            default: ;
         endcase
      endfunction

      // one accepted req beat: predict the sample it will produce
      function void note_request(input logic restart);
         int               len;
         int               beams;
         int               idx;
         int               quad;
         int               r;
         int               a;
         bit               flip;
         int               bc;
         int               bs;
         int               tc;
         int               ts;
         lfm_pkg::rsp_type e;
         len = chirp_length;
         if (len < 1) len = 1;
         if (len > lfm_pkg::MAX_LENGTH) len = lfm_pkg::MAX_LENGTH;
         beams = beam_total;
         if (beams < 1) beams = 1;
         if (beams > lfm_pkg::BEAM_CAP) beams = lfm_pkg::BEAM_CAP;
         if (restart) begin
            sample_cnt = '0;
            beam_cnt   = '0;
         end
         if (sample_cnt == 16'd0) begin
            phase_acc  = '0;
            phase_step = start_step;
         end
         idx  = int'(phase_acc >> (32 - TBITS));
         quad = (idx >> (TBITS - 2)) & 3;
         r    = idx & (QTR - 1);
         flip = r > OCT;
         a    = flip ? QTR - r : r;
         bc   = flip ? sin_oct[a] : cos_oct[a];
         bs   = flip ? cos_oct[a] : sin_oct[a];
         case (quad)
            0: begin tc = bc;  ts = bs;  end
            1: begin tc = -bs; ts = bc;  end
            2: begin tc = -bc; ts = -bs; end
            default: begin tc = bs; ts = -bc; end
         endcase
         e.in_phase      = scaled(tc);
         e.quadrature    = iq_enable ? scaled(ts) : 16'd0;
         e.sample_number = sample_cnt;
         e.beam_number   = beam_cnt;
         e.chirp_end     = int'(sample_cnt) >= len - 1;
         e.burst_end     = e.chirp_end && int'(beam_cnt) >= beams - 1;
         expected_samples = {expected_samples, e};
         phase_acc  = phase_acc + phase_step;
         phase_step = phase_step + step_change;
         if (e.chirp_end) begin
            sample_cnt = '0;
            beam_cnt   = e.burst_end ? 8'd0 : beam_cnt + 8'd1;
         end else begin
            sample_cnt = sample_cnt + 16'd1;
         end
      endfunction

      task report(input string msg);
         errors++;
         // quiet after the first fifty
         if (errors <= 50) $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task compare_field(input string name, input int got, input int want);
         if (got != want)
            report($sformatf("beat %0d %s got %0d want %0d", checked, name, got, want));
      endtask

      task check_sample(input lfm_pkg::rsp_type got);
         lfm_pkg::rsp_type want;
         if (expected_samples.size() == 0) begin
            report($sformatf("rsp beat %0d with nothing pending", checked));
         end else begin
            want = expected_samples.pop_front();
            compare_field("in_phase", int'(got.in_phase), int'(want.in_phase));
            compare_field("quadrature", int'(got.quadrature), int'(want.quadrature));
            compare_field("sample_number", got.sample_number, want.sample_number);
            compare_field("beam_number", got.beam_number, want.beam_number);
            compare_field("chirp_end", got.chirp_end, want.chirp_end);
            compare_field("burst_end", got.burst_end, want.burst_end);
         end
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   chirp_scoreboard board;
   int              req_idle_pct;
   int              rsp_idle_pct;
   bit              long_hold_req;

   lfm_chirp_generator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_lfm_chirp_generator_top: FAIL");
      $finish;
   end

   // output side: check each beat, then choose tready for the next edge
   initial begin
      lfm_pkg::rsp_type got;
      int               stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.in_phase      = rsp_tdata[15:0];
            got.quadrature    = rsp_tdata[31:16];
            got.sample_number = rsp_tdata[47:32];
            got.beam_number   = rsp_tdata[55:48];
            got.chirp_end     = rsp_tlast;
            got.burst_end     = rsp_tuser[0];
            board.check_sample(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(99) < rsp_idle_pct) begin
            stall_left = $urandom_range(9, 1) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // leaves req_tvalid high so back-to-back beats keep it asserted without a gap
   task automatic send_sample(input logic restart);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(restart);
   endtask

   task automatic wait_drained();
      while (board.expected_samples.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int restart_pct);
      repeat (count) send_sample($urandom_range(99) < restart_pct);
      req_tvalid <= 1'b0;
      wait_drained();
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
   endtask

   task automatic load_registers(input logic [31:0] start_step, input logic [31:0] step_change,
                                 input logic [31:0] amplitude, input logic [31:0] iq_enable,
                                 input logic [31:0] chirp_length, input logic [31:0] beam_total);
      write_reg(lfm_pkg::CSR_START_STEP, start_step);
      write_reg(lfm_pkg::CSR_STEP_CHANGE, step_change);
      write_reg(lfm_pkg::CSR_AMPLITUDE, amplitude);
      write_reg(lfm_pkg::CSR_IQ_ENABLE, iq_enable);
      write_reg(lfm_pkg::CSR_CHIRP_LEN, chirp_length);
      write_reg(lfm_pkg::CSR_BEAM_TOTAL, beam_total);
      csr_valid <= 1'b0;
   endtask

   // biased towards extremes, short chirps and few beams
   function automatic logic [31:0] pick_value(input logic [2:0] idx);
      logic [31:0] junk;
      int          sel;
      junk = $urandom();
      sel  = $urandom_range(9);
      case (idx)
         lfm_pkg::CSR_START_STEP:
            return (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : junk;
         lfm_pkg::CSR_STEP_CHANGE:
            if (sel == 0) return 32'h8000_0000;
            else if (sel == 1) return 32'h7FFF_FFFF;
            else if (sel < 6) return 32'($urandom_range(2000)) - 32'd1000;
            else return junk;
         lfm_pkg::CSR_AMPLITUDE:
            if (sel == 0) return {junk[31:15], 15'd0};
            else if (sel == 1) return {junk[31:15], 15'h7FFF};
            else return junk;
         lfm_pkg::CSR_CHIRP_LEN:
            if (sel == 0) return {junk[31:17], 17'd0};
            else if (sel == 1) return {junk[31:17], 17'h1FFFF};
            else if (sel == 2) return 32'd1;
            else if (sel < 6) return {junk[31:17], 17'($urandom_range(40, 2))};
            else return 32'($urandom_range(40, 2));
         lfm_pkg::CSR_BEAM_TOTAL:
            if (sel == 0) return {junk[31:9], 9'd0};
            else if (sel == 1) return 32'd256;
            else if (sel == 2) return 32'($urandom_range(511, 257));
            else return {junk[31:9], 9'($urandom_range(6, 1))};
         default:
            return junk;
      endcase
   endfunction

   task automatic shuffle_registers();
      load_registers(pick_value(lfm_pkg::CSR_START_STEP), pick_value(lfm_pkg::CSR_STEP_CHANGE),
                     pick_value(lfm_pkg::CSR_AMPLITUDE), pick_value(lfm_pkg::CSR_IQ_ENABLE),
                     pick_value(lfm_pkg::CSR_CHIRP_LEN), pick_value(lfm_pkg::CSR_BEAM_TOTAL));
   endtask

   function automatic int pick_idle_pct();
      int sel;
      sel = $urandom_range(3);
      return (sel == 0) ? 0 : (sel == 1) ? 15 : (sel == 2) ? 35 : 60;
   endfunction

   initial begin
      logic [2:0] idx;
      int         random_sent;
      int         n;
      board         = new();
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      long_hold_req = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= lfm_pkg::CSR_START_STEP;
      csr_data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset, then a restart
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      send_sample(1'b0);
      send_sample(1'b0);
      send_sample(1'b1);
      req_tvalid <= 1'b0;
      wait_drained();

      // quarter-turn steps walk all four quadrants; two beams of four
      load_registers(32'h4000_0000, 32'd0, 32'h7FFF, 32'd1, 32'd4, 32'd2);
      run_phase(8, 0);

      // zero length and zero beams clamp to one, zero amplitude, real mode
      load_registers(32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
      run_phase(3, 0);

      // beam count above the cap, largest positive step change
      load_registers(32'h0123_4567, 32'h7FFF_FFFF, 32'h7FFF, 32'd1, 32'd3, 32'd300);
      send_sample(1'b0);
      send_sample(1'b1);
      run_phase(2, 0);

      // shorten the chirp under a counter that is already past the new end;
      // a new start step only applies at the next chirp start
      load_registers(32'h0100_0000, 32'h0000_1000, 32'h4000, 32'd1, 32'd20, 32'd1);
      run_phase(6, 0);
      write_reg(lfm_pkg::CSR_CHIRP_LEN, 32'd3);
      write_reg(lfm_pkg::CSR_START_STEP, 32'h2000_0000);
      write_reg(CSR_SPARE_LO, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_HI, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      run_phase(3, 0);

      // output held off for a long stretch while input keeps coming
      shuffle_registers();
      long_hold_req = 1'b1;
      run_phase(40, 5);

      // full beam count reaches the top beam number
      load_registers(pick_value(lfm_pkg::CSR_START_STEP), pick_value(lfm_pkg::CSR_STEP_CHANGE),
                     32'h7FFF, 32'd1, 32'd1, 32'd256);
      send_sample(1'b1);
      run_phase(259, 0);

      // beats sent by the directed phases above
      random_sent = 327;
      while (random_sent < RANDOM_ITEMS - CLOSING_ITEMS) begin
         req_idle_pct = pick_idle_pct();
         rsp_idle_pct = pick_idle_pct();
         if ($urandom_range(1) == 1) begin
            shuffle_registers();
         end else begin
            idx = 3'($urandom_range(7));
            write_reg(idx, pick_value(idx));
            csr_valid <= 1'b0;
         end
         n = $urandom_range(60, 5);
         run_phase(n, 5);
         random_sent += n;
      end

      // closing part runs flat out
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      shuffle_registers();
      run_phase(CLOSING_ITEMS, 5);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.expected_samples.size() != 0)
         board.report($sformatf("%0d samples never arrived", board.expected_samples.size()));
      if (board.errors == 0) begin
         $display("tb_lfm_chirp_generator_top: PASS");
      end else begin
         $display("tb_lfm_chirp_generator_top: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/lfm_pkg.sv
rtl/lfm_csr.sv
rtl/lfm_phase_seq.sv
rtl/lfm_trig_rom.sv
rtl/lfm_scaler.sv
rtl/lfm_chirp_generator_top.sv
tb/sv/tb_lfm_chirp_generator_top.sv
